FILE: sv/ffra_pkg.sv
// Shared constants, codes and command/status types of the range allocator.
package ffra_pkg;

  localparam int unsigned DIES         = 2;
  localparam int unsigned FREE_ENTRIES = 16;
  localparam int unsigned RECORDS      = 32;
  localparam int unsigned RES_IDS      = 4096;

  localparam int unsigned POOLS      = 2 * DIES;
  localparam int unsigned FREE_DEPTH = POOLS * FREE_ENTRIES;
  localparam int unsigned FREE_AW    = $clog2(FREE_DEPTH);
  localparam int unsigned POOL_W     = $clog2(POOLS);
  localparam int unsigned USED_W     = $clog2(FREE_ENTRIES + 1);
  localparam int unsigned REC_AW     = $clog2(RECORDS);
  localparam int unsigned SCAN_MAX   = (FREE_ENTRIES > RECORDS) ? FREE_ENTRIES : RECORDS;
  localparam int unsigned SCAN_W     = $clog2(SCAN_MAX + 1);

  localparam int unsigned MODE_W   = 3;
  localparam int unsigned ID_W     = 12;
  localparam int unsigned LEN_W    = 13;
  localparam int unsigned HANDLE_W = 32;
  localparam int unsigned INST_W   = 64;
  localparam int unsigned FREE_W   = ID_W + LEN_W;
  localparam int unsigned INFO_W   = LEN_W + ID_W + 2;
  localparam int unsigned REC_W    = HANDLE_W + INST_W + INFO_W;

  localparam logic [MODE_W-1:0] MODE_ADD      = 3'd0;
  localparam logic [MODE_W-1:0] MODE_ACQ      = 3'd1;
  localparam logic [MODE_W-1:0] MODE_REL      = 3'd2;
  localparam logic [MODE_W-1:0] MODE_REL_INST = 3'd3;
  localparam logic [MODE_W-1:0] MODE_QUERY    = 3'd4;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_PARA      = 3'd1,
    ST_UNAVAIL   = 3'd2,
    ST_NOTFOUND  = 3'd3,
    ST_POOLFULL  = 3'd4,
    ST_TABLEFULL = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    IDX_HOLD = 2'd0,
    IDX_CLR  = 2'd1,
    IDX_INC  = 2'd2
  } idx_op_e;

  typedef enum logic [2:0] {
    FW_NONE   = 3'd0,
    FW_ADD    = 3'd1,
    FW_SPLIT  = 3'd2,
    FW_SHIFT  = 3'd3,
    FW_APPEND = 3'd4
  } fw_op_e;

  typedef enum logic [1:0] {
    RES_PLAIN = 2'd0,
    RES_ACQ   = 2'd1,
    RES_QUERY = 2'd2
  } res_kind_e;

  typedef struct packed {
    logic      cap;
    idx_op_e   idx_op;
    fw_op_e    fw_op;
    logic      used_dec;
    logic      rec_wr;
    logic      rec_clr;
    logic      hit_ld;
    logic      res_ld;
    status_e   res_st;
    res_kind_e res_kind;
    logic      bulk_clr;
    logic      bulk_set;
    logic      out_ld;
  } cmd_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              add_bad;
    logic              cnt_zero;
    logic              pool_full;
    logic              acq_bad;
    logic              slot_none;
    logic              fscan_end;
    logic              fit;
    logic              exact;
    logic              shift_end;
    logic              rscan_last;
    logic              rec_hit;
    logic              inst_hit;
    logic              tgt_full;
    logic              q_bad;
    logic              bulk_full;
    logic              out_busy;
  } stat_t;

endpackage

FILE: sv/ffra_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ffra_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: sv/ffra_ctrl.sv
// Sequencer of the range allocator: decodes a request and steps the datapath.
module ffra_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  ffra_pkg::stat_t stat_i,
  output ffra_pkg::cmd_t  cmd_o
);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_DISP   = 8'b0000_0010,
    S_FSCAN  = 8'b0000_0100,
    S_FSHIFT = 8'b0000_1000,
    S_RWRITE = 8'b0001_0000,
    S_RSCAN  = 8'b0010_0000,
    S_BSCAN  = 8'b0100_0000,
    S_DONE   = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.cap = 1'b1;
          state_d   = S_DISP;
        end
      end
      S_DISP: begin
        cmd_o.idx_op = ffra_pkg::IDX_CLR;
        case (stat_i.mode)
          ffra_pkg::MODE_ADD: begin
            cmd_o.res_ld = 1'b1;
            if (stat_i.add_bad) begin
              cmd_o.res_st = ffra_pkg::ST_PARA;
            end else if (stat_i.cnt_zero) begin
              cmd_o.res_st = ffra_pkg::ST_OK;
            end else if (stat_i.pool_full) begin
              cmd_o.res_st = ffra_pkg::ST_POOLFULL;
            end else begin
              cmd_o.fw_op  = ffra_pkg::FW_ADD;
              cmd_o.res_st = ffra_pkg::ST_OK;
            end
            state_d = S_DONE;
          end
          ffra_pkg::MODE_ACQ: begin
            if (stat_i.acq_bad) begin
              cmd_o.res_ld = 1'b1;
              cmd_o.res_st = ffra_pkg::ST_PARA;
              state_d      = S_DONE;
            end else begin
              state_d = S_FSCAN;
            end
          end
          ffra_pkg::MODE_REL, ffra_pkg::MODE_QUERY: begin
            state_d = S_RSCAN;
          end
          ffra_pkg::MODE_REL_INST: begin
            cmd_o.bulk_clr = 1'b1;
            state_d        = S_BSCAN;
          end
          default: begin
            cmd_o.res_ld = 1'b1;
            cmd_o.res_st = ffra_pkg::ST_PARA;
            state_d      = S_DONE;
          end
        endcase
      end
      S_FSCAN: begin
        if (stat_i.fscan_end) begin
          cmd_o.res_ld = 1'b1;
          cmd_o.res_st = ffra_pkg::ST_UNAVAIL;
          state_d      = S_DONE;
        end else if (stat_i.fit) begin
          if (stat_i.slot_none) begin
            cmd_o.res_ld = 1'b1;
            cmd_o.res_st = ffra_pkg::ST_TABLEFULL;
            state_d      = S_DONE;
          end else begin
            cmd_o.hit_ld = 1'b1;
            if (stat_i.exact) begin
              cmd_o.idx_op = ffra_pkg::IDX_INC;
              state_d      = S_FSHIFT;
            end else begin
              cmd_o.fw_op = ffra_pkg::FW_SPLIT;
              state_d     = S_RWRITE;
            end
          end
        end else begin
          cmd_o.idx_op = ffra_pkg::IDX_INC;
        end
      end
      S_FSHIFT: begin
        if (stat_i.shift_end) begin
          cmd_o.used_dec = 1'b1;
          state_d        = S_RWRITE;
        end else begin
          cmd_o.fw_op  = ffra_pkg::FW_SHIFT;
          cmd_o.idx_op = ffra_pkg::IDX_INC;
        end
      end
      S_RWRITE: begin
        cmd_o.rec_wr   = 1'b1;
        cmd_o.res_ld   = 1'b1;
        cmd_o.res_st   = ffra_pkg::ST_OK;
        cmd_o.res_kind = ffra_pkg::RES_ACQ;
        state_d        = S_DONE;
      end
      S_RSCAN: begin
        if (stat_i.rec_hit) begin
          cmd_o.res_ld = 1'b1;
          state_d      = S_DONE;
          if (stat_i.mode == ffra_pkg::MODE_REL) begin
            if (stat_i.tgt_full) begin
              cmd_o.res_st = ffra_pkg::ST_POOLFULL;
            end else begin
              cmd_o.fw_op   = ffra_pkg::FW_APPEND;
              cmd_o.rec_clr = 1'b1;
              cmd_o.res_st  = ffra_pkg::ST_OK;
            end
          end else if (stat_i.q_bad) begin
            cmd_o.res_st = ffra_pkg::ST_PARA;
          end else begin
            cmd_o.res_st   = ffra_pkg::ST_OK;
            cmd_o.res_kind = ffra_pkg::RES_QUERY;
          end
        end else if (stat_i.rscan_last) begin
          cmd_o.res_ld = 1'b1;
          cmd_o.res_st = ffra_pkg::ST_NOTFOUND;
          state_d      = S_DONE;
        end else begin
          cmd_o.idx_op = ffra_pkg::IDX_INC;
        end
      end
      S_BSCAN: begin
        if (stat_i.inst_hit) begin
          if (stat_i.tgt_full) begin
            cmd_o.bulk_set = 1'b1;
          end else begin
            cmd_o.fw_op   = ffra_pkg::FW_APPEND;
            cmd_o.rec_clr = 1'b1;
          end
        end
        if (stat_i.rscan_last) begin
          cmd_o.res_ld = 1'b1;
          if (stat_i.bulk_full || (stat_i.inst_hit && stat_i.tgt_full)) begin
            cmd_o.res_st = ffra_pkg::ST_POOLFULL;
          end else begin
            cmd_o.res_st = ffra_pkg::ST_OK;
          end
          state_d = S_DONE;
        end else begin
          cmd_o.idx_op = ffra_pkg::IDX_INC;
        end
      end
      S_DONE: begin
        if (!stat_i.out_busy) begin
          cmd_o.out_ld = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: sv/ffra_dp.sv
// Datapath of the range allocator: free lists, record table, counters, result.
module ffra_dp (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [ffra_pkg::MODE_W-1:0]    mode_i,
  input  logic                           res_type_i,
  input  logic                           die_i,
  input  logic [ffra_pkg::LEN_W-1:0]     count_i,
  input  logic [ffra_pkg::ID_W-1:0]      start_id_i,
  input  logic [ffra_pkg::HANDLE_W-1:0]  handle_i,
  input  logic [ffra_pkg::INST_W-1:0]    instance_req_i,
  input  logic [ffra_pkg::ID_W-1:0]      index_i,
  input  logic                           out_ready_i,
  output logic                           out_valid_o,
  output logic [2:0]                     status_o,
  output logic [ffra_pkg::HANDLE_W-1:0]  handle_out_o,
  output logic                           die_out_o,
  output logic [ffra_pkg::ID_W-1:0]      res_id_out_o,
  input  ffra_pkg::cmd_t                 cmd_i,
  output ffra_pkg::stat_t                stat_o
);

  localparam int unsigned FAW  = ffra_pkg::FREE_AW;
  localparam int unsigned LW   = ffra_pkg::LEN_W;
  localparam int unsigned IW   = ffra_pkg::ID_W;
  localparam int unsigned HW   = ffra_pkg::HANDLE_W;
  localparam int unsigned NW   = ffra_pkg::INST_W;
  localparam int unsigned FW   = ffra_pkg::FREE_W;
  localparam int unsigned INW  = ffra_pkg::INFO_W;
  localparam int unsigned RW   = ffra_pkg::REC_W;
  localparam int unsigned RAW  = ffra_pkg::REC_AW;
  localparam int unsigned SW   = ffra_pkg::SCAN_W;
  localparam int unsigned UW   = ffra_pkg::USED_W;
  localparam int unsigned PW   = ffra_pkg::POOL_W;

  logic [ffra_pkg::MODE_W-1:0] req_mode_q;
  logic                        req_type_q;
  logic                        req_die_q;
  logic [LW-1:0]               req_count_q;
  logic [IW-1:0]               req_sid_q;
  logic [HW-1:0]               req_handle_q;
  logic [NW-1:0]               req_inst_q;
  logic [IW-1:0]               req_index_q;

  logic [SW-1:0]  idx_q, idx_d;
  logic [UW-1:0]  used_q [ffra_pkg::POOLS];
  logic [ffra_pkg::RECORDS-1:0] valid_q;
  logic [HW-1:0]  counter_q;
  logic           bulk_full_q;
  logic [RAW-1:0] slot_q;
  logic [IW-1:0]  hstart_q;

  ffra_pkg::status_e res_st_q;
  logic [HW-1:0]     res_handle_q;
  logic              res_die_q;
  logic [IW-1:0]     res_id_q;

  logic          out_valid_q;
  logic [2:0]    out_status_q;
  logic [HW-1:0] out_handle_q;
  logic          out_die_q;
  logic [IW-1:0] out_id_q;

  logic [PW-1:0]  pool;
  logic [PW-1:0]  tpool;
  logic [UW-1:0]  used_p;
  logic [UW-1:0]  used_t;
  logic [FAW-1:0] f_raddr;
  logic [FAW-1:0] f_waddr;
  logic [FW-1:0]  f_rdata;
  logic [FW-1:0]  f_wdata;
  logic           f_we;
  logic [IW-1:0]  f_start;
  logic [LW-1:0]  f_len;
  logic [RW-1:0]  r_rdata;
  logic [RW-1:0]  r_wdata;
  logic [HW-1:0]  r_handle;
  logic [NW-1:0]  r_inst;
  logic [INW-1:0] r_info;
  logic [LW-1:0]  r_len;
  logic [IW-1:0]  r_start;
  logic           r_type;
  logic           r_die;
  logic           r_die_ok;
  logic [RAW-1:0] ridx;
  logic [RAW-1:0] slot;
  logic           r_valid;
  logic           append_we;

  assign pool   = PW'(32'(req_type_q) * ffra_pkg::DIES + 32'(req_die_q));
  assign used_p = used_q[pool];

  assign f_start = f_rdata[FW-1 -: IW];
  assign f_len   = f_rdata[LW-1:0];

  assign r_handle = r_rdata[RW-1 -: HW];
  assign r_inst   = r_rdata[INW +: NW];
  assign r_info   = r_rdata[INW-1:0];
  assign r_len    = r_info[LW-1:0];
  assign r_start  = r_info[LW +: IW];
  assign r_type   = r_info[LW + IW];
  assign r_die    = r_info[LW + IW + 1];
  assign r_die_ok = (32'(r_die) < ffra_pkg::DIES);
  assign tpool    = PW'(32'(r_type) * ffra_pkg::DIES + (r_die_ok ? 32'(r_die) : 32'd0));
  assign used_t   = used_q[tpool];

  assign ridx    = idx_q[RAW-1:0];
  assign r_valid = valid_q[ridx];

  always_comb begin
    case (cmd_i.idx_op)
      ffra_pkg::IDX_CLR: idx_d = '0;
      ffra_pkg::IDX_INC: idx_d = idx_q + SW'(1);
      default:           idx_d = idx_q;
    endcase
  end

  assign f_raddr = FAW'(32'(pool) * ffra_pkg::FREE_ENTRIES + 32'(idx_d));

  always_comb begin
    slot = '0;
    for (int i = ffra_pkg::RECORDS - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        slot = RAW'(i);
      end
    end
  end

  assign append_we = (cmd_i.fw_op == ffra_pkg::FW_APPEND) && (r_len != '0);

  always_comb begin
    f_we    = 1'b0;
    f_waddr = '0;
    f_wdata = f_rdata;
    case (cmd_i.fw_op)
      ffra_pkg::FW_ADD: begin
        f_we    = 1'b1;
        f_waddr = FAW'(32'(pool) * ffra_pkg::FREE_ENTRIES + 32'(used_p));
        f_wdata = {req_sid_q, req_count_q};
      end
      ffra_pkg::FW_SPLIT: begin
        f_we    = 1'b1;
        f_waddr = FAW'(32'(pool) * ffra_pkg::FREE_ENTRIES + 32'(idx_q));
        f_wdata = {f_start + req_count_q[IW-1:0], f_len - req_count_q};
      end
      ffra_pkg::FW_SHIFT: begin
        f_we    = 1'b1;
        f_waddr = FAW'(32'(pool) * ffra_pkg::FREE_ENTRIES + 32'(idx_q) - 32'd1);
        f_wdata = f_rdata;
      end
      ffra_pkg::FW_APPEND: begin
        f_we    = append_we;
        f_waddr = FAW'(32'(tpool) * ffra_pkg::FREE_ENTRIES + 32'(used_t));
        f_wdata = {r_start, r_len};
      end
      default: begin
        f_we = 1'b0;
      end
    endcase
  end

  assign r_wdata = {counter_q + HW'(1), req_inst_q, req_die_q, req_type_q, hstart_q, req_count_q};

  ffra_ram #(
    .WIDTH (FW),
    .DEPTH (ffra_pkg::FREE_DEPTH)
  ) u_free_ram (
    .clk_i   (clk_i),
    .we_i    (f_we),
    .waddr_i (f_waddr),
    .wdata_i (f_wdata),
    .raddr_i (f_raddr),
    .rdata_o (f_rdata)
  );

  ffra_ram #(
    .WIDTH (RW),
    .DEPTH (ffra_pkg::RECORDS)
  ) u_rec_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.rec_wr),
    .waddr_i (slot_q),
    .wdata_i (r_wdata),
    .raddr_i (idx_d[RAW-1:0]),
    .rdata_o (r_rdata)
  );

  always_comb begin
    stat_o            = '0;
    stat_o.mode       = req_mode_q;
    stat_o.add_bad    = (32'(req_die_q) >= ffra_pkg::DIES) ||
                        (32'(req_sid_q) + 32'(req_count_q) > ffra_pkg::RES_IDS);
    stat_o.cnt_zero   = (req_count_q == '0);
    stat_o.pool_full  = (32'(used_p) >= ffra_pkg::FREE_ENTRIES);
    stat_o.acq_bad    = (32'(req_die_q) >= ffra_pkg::DIES) || (req_count_q == '0);
    stat_o.slot_none  = &valid_q;
    stat_o.fscan_end  = (32'(idx_q) == 32'(used_p));
    stat_o.fit        = (f_len >= req_count_q);
    stat_o.exact      = (f_len == req_count_q);
    stat_o.shift_end  = (32'(idx_q) >= 32'(used_p));
    stat_o.rscan_last = (32'(idx_q) == ffra_pkg::RECORDS - 1);
    stat_o.rec_hit    = r_valid && (r_handle == req_handle_q);
    stat_o.inst_hit   = r_valid && (r_inst == req_inst_q);
    stat_o.tgt_full   = (r_len != '0) && (32'(used_t) >= ffra_pkg::FREE_ENTRIES);
    stat_o.q_bad      = (r_type != req_type_q) || ({1'b0, req_index_q} >= r_len);
    stat_o.bulk_full  = bulk_full_q;
    stat_o.out_busy   = out_valid_q && !out_ready_i;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap) begin
      req_mode_q   <= mode_i;
      req_type_q   <= res_type_i;
      req_die_q    <= die_i;
      req_count_q  <= count_i;
      req_sid_q    <= start_id_i;
      req_handle_q <= handle_i;
      req_inst_q   <= instance_req_i;
      req_index_q  <= index_i;
    end
    if (cmd_i.hit_ld) begin
      slot_q   <= slot;
      hstart_q <= f_start;
    end
    if (cmd_i.res_ld) begin
      res_st_q <= cmd_i.res_st;
      case (cmd_i.res_kind)
        ffra_pkg::RES_ACQ: begin
          res_handle_q <= counter_q + HW'(1);
          res_die_q    <= req_die_q;
          res_id_q     <= hstart_q;
        end
        ffra_pkg::RES_QUERY: begin
          res_handle_q <= '0;
          res_die_q    <= r_die;
          res_id_q     <= r_start + req_index_q;
        end
        default: begin
          res_handle_q <= '0;
          res_die_q    <= 1'b0;
          res_id_q     <= '0;
        end
      endcase
    end
    if (cmd_i.out_ld) begin
      out_status_q <= res_st_q;
      out_handle_q <= res_handle_q;
      out_die_q    <= res_die_q;
      out_id_q     <= res_id_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      valid_q     <= '0;
      counter_q   <= '0;
      bulk_full_q <= 1'b0;
      out_valid_q <= 1'b0;
      for (int p = 0; p < ffra_pkg::POOLS; p++) begin
        used_q[p] <= '0;
      end
    end else begin
      idx_q <= idx_d;
      if (cmd_i.fw_op == ffra_pkg::FW_ADD) begin
        used_q[pool] <= used_p + UW'(1);
      end else if (append_we) begin
        used_q[tpool] <= used_t + UW'(1);
      end else if (cmd_i.used_dec) begin
        used_q[pool] <= used_p - UW'(1);
      end
      if (cmd_i.rec_wr) begin
        valid_q[slot_q] <= 1'b1;
        counter_q       <= counter_q + HW'(1);
      end
      if (cmd_i.rec_clr) begin
        valid_q[ridx] <= 1'b0;
      end
      if (cmd_i.bulk_clr) begin
        bulk_full_q <= 1'b0;
      end else if (cmd_i.bulk_set) begin
        bulk_full_q <= 1'b1;
      end
      if (cmd_i.out_ld) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = out_status_q;
  assign handle_out_o = out_handle_q;
  assign die_out_o    = out_die_q;
  assign res_id_out_o = out_id_q;

endmodule

FILE: sv/first_fit_range_allocator.sv
// Top level of the first-fit ID range allocator: sequencer plus datapath.
// An add does no scan; an acquire scans the free list and, on an exact fit, shifts the entries behind it;
// release and query scan the records up to the first hit; release by instance scans every record.
// One request at a time, set by the single read port of the free-list and record RAMs.
// The result register frees the input side: a new request is taken while a result waits.
// rst_ni clears all lists to empty, all records to unused and the handle counter to zero.
module first_fit_range_allocator (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [ffra_pkg::MODE_W-1:0]   mode_i,
  input  logic                          res_type_i,
  input  logic                          die_i,
  input  logic [ffra_pkg::LEN_W-1:0]    count_i,
  input  logic [ffra_pkg::ID_W-1:0]     start_id_i,
  input  logic [ffra_pkg::HANDLE_W-1:0] handle_i,
  input  logic [ffra_pkg::INST_W-1:0]   instance_req_i,
  input  logic [ffra_pkg::ID_W-1:0]     index_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [2:0]                    status_o,
  output logic [ffra_pkg::HANDLE_W-1:0] handle_out_o,
  output logic                          die_out_o,
  output logic [ffra_pkg::ID_W-1:0]     res_id_out_o
);

  ffra_pkg::cmd_t  cmd;
  ffra_pkg::stat_t stat;

  ffra_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  ffra_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .mode_i         (mode_i),
    .res_type_i     (res_type_i),
    .die_i          (die_i),
    .count_i        (count_i),
    .start_id_i     (start_id_i),
    .handle_i       (handle_i),
    .instance_req_i (instance_req_i),
    .index_i        (index_i),
    .out_ready_i    (out_ready_i),
    .out_valid_o    (out_valid_o),
    .status_o       (status_o),
    .handle_out_o   (handle_out_o),
    .die_out_o      (die_out_o),
    .res_id_out_o   (res_id_out_o),
    .cmd_i          (cmd),
    .stat_o         (stat)
  );

endmodule

FILE: sv/ffra_chk.sv
// Port-level checks of the range allocator and their bind to the top level.
module ffra_chk (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_o,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic [2:0]                    status_o,
  input logic [ffra_pkg::HANDLE_W-1:0] handle_out_o,
  input logic                          die_out_o,
  input logic [ffra_pkg::ID_W-1:0]     res_id_out_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped before it was taken");

  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request taken while the previous one is in work");

  a_fail_no_handle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != 3'(ffra_pkg::ST_OK)) |-> (handle_out_o == '0))
    else $error("handle on a failed request");

  a_fail_no_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != 3'(ffra_pkg::ST_OK)) |-> (res_id_out_o == '0) && !die_out_o)
    else $error("id or die on a failed request");

endmodule

bind first_fit_range_allocator ffra_chk u_ffra_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .status_o     (status_o),
  .handle_out_o (handle_out_o),
  .die_out_o    (die_out_o),
  .res_id_out_o (res_id_out_o)
);

FILE: tb/tb_top.sv
// Self-checking testbench of the first-fit range allocator: directed table plus random traffic.
`timescale 1ns / 100ps

module tb_top;

  localparam int unsigned IDLE_LIMIT = 20000;
  localparam int unsigned N_RANDOM   = 1300;

  typedef struct packed {
    logic [2:0]  mode;
    logic        rtype;
    logic        die;
    logic [12:0] count;
    logic [11:0] sid;
    logic [31:0] handle;
    logic [63:0] inst;
    logic [11:0] idx;
  } request_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] handle;
    logic        die;
    logic [11:0] rid;
  } answer_t;

  typedef struct {
    request_t req;
    logic     has_exp;
    answer_t  exp;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [2:0] mode_i = '0;
  logic res_type_i = 1'b0;
  logic die_i = 1'b0;
  logic [12:0] count_i = '0;
  logic [11:0] start_id_i = '0;
  logic [31:0] handle_i = '0;
  logic [63:0] instance_req_i = '0;
  logic [11:0] index_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [2:0] status_o;
  logic [31:0] handle_out_o;
  logic die_out_o;
  logic [11:0] res_id_out_o;

  first_fit_range_allocator dut (.*);

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // allocator model state
  logic [11:0] m_start [ffra_pkg::POOLS][ffra_pkg::FREE_ENTRIES];
  logic [12:0] m_len   [ffra_pkg::POOLS][ffra_pkg::FREE_ENTRIES];
  int unsigned m_used  [ffra_pkg::POOLS];
  logic        r_valid [ffra_pkg::RECORDS];
  logic [31:0] r_handle[ffra_pkg::RECORDS];
  logic [63:0] r_inst  [ffra_pkg::RECORDS];
  logic [12:0] r_len   [ffra_pkg::RECORDS];
  logic [11:0] r_start [ffra_pkg::RECORDS];
  logic        r_type  [ffra_pkg::RECORDS];
  logic        r_die   [ffra_pkg::RECORDS];
  logic [31:0] m_counter;

  answer_t answers_due[$];
  row_t rows[$];
  int unsigned mismatches = 0, n_sent = 0, n_got = 0, n_ok_acq = 0;
  int unsigned idle_cycles = 0;
  logic hold_rx = 1'b0;

  function automatic void add_row(row_t r);
    rows.insert(rows.size(), r);
  endfunction

  function automatic bit pool_push(int p, logic [11:0] s, logic [12:0] l);
    if (m_used[p] >= ffra_pkg::FREE_ENTRIES) return 0;
    m_start[p][m_used[p]] = s;
    m_len[p][m_used[p]] = l;
    m_used[p]++;
    return 1;
  endfunction

  function automatic bit slot_release(int r);
    if (r_len[r] != 0 &&
        !pool_push(r_type[r] * ffra_pkg::DIES + r_die[r], r_start[r], r_len[r]))
      return 0;
    r_valid[r] = 0;
    return 1;
  endfunction

  function automatic int record_lookup(logic [31:0] h);
    for (int i = 0; i < ffra_pkg::RECORDS; i++)
      if (r_valid[i] && r_handle[i] == h) return i;
    return -1;
  endfunction

  function automatic answer_t allocate_step(request_t q);
    answer_t a;
    int p, hit, slot, r;
    a = '0;
    a.status = ffra_pkg::ST_PARA;
    p = q.rtype * ffra_pkg::DIES + q.die;
    case (q.mode)
      ffra_pkg::MODE_ADD: begin
        if (32'(q.sid) + 32'(q.count) > ffra_pkg::RES_IDS) a.status = ffra_pkg::ST_PARA;
        else if (q.count == 0) a.status = ffra_pkg::ST_OK;
        else a.status = pool_push(p, q.sid, q.count) ? ffra_pkg::ST_OK : ffra_pkg::ST_POOLFULL;
      end
      ffra_pkg::MODE_ACQ: begin
        if (q.count != 0) begin
          hit = -1;
          slot = -1;
          for (int k = 0; k < m_used[p]; k++)
            if (hit < 0 && m_len[p][k] >= q.count) hit = k;
          for (int i = 0; i < ffra_pkg::RECORDS; i++)
            if (slot < 0 && !r_valid[i]) slot = i;
          if (hit < 0) a.status = ffra_pkg::ST_UNAVAIL;
          else if (slot < 0) a.status = ffra_pkg::ST_TABLEFULL;
          else begin
            a.rid = m_start[p][hit];
            if (m_len[p][hit] == q.count) begin
              for (int k = hit; k + 1 < m_used[p]; k++) begin
                m_start[p][k] = m_start[p][k+1];
                m_len[p][k] = m_len[p][k+1];
              end
              m_used[p]--;
            end else begin
              m_start[p][hit] = a.rid + q.count[11:0];
              m_len[p][hit] = m_len[p][hit] - q.count;
            end
            m_counter++;
            r_valid[slot] = 1;
            r_handle[slot] = m_counter;
            r_inst[slot] = q.inst;
            r_len[slot] = q.count;
            r_start[slot] = a.rid;
            r_type[slot] = q.rtype;
            r_die[slot] = q.die;
            a.status = ffra_pkg::ST_OK;
            a.handle = m_counter;
            a.die = q.die;
          end
        end
      end
      ffra_pkg::MODE_REL: begin
        r = record_lookup(q.handle);
        if (r < 0) a.status = ffra_pkg::ST_NOTFOUND;
        else a.status = slot_release(r) ? ffra_pkg::ST_OK : ffra_pkg::ST_POOLFULL;
      end
      ffra_pkg::MODE_REL_INST: begin
        a.status = ffra_pkg::ST_OK;
        for (int i = 0; i < ffra_pkg::RECORDS; i++)
          if (r_valid[i] && r_inst[i] == q.inst && !slot_release(i))
            a.status = ffra_pkg::ST_POOLFULL;
      end
      ffra_pkg::MODE_QUERY: begin
        r = record_lookup(q.handle);
        if (r < 0) a.status = ffra_pkg::ST_NOTFOUND;
        else if (r_type[r] != q.rtype || 13'(q.idx) >= r_len[r]) a.status = ffra_pkg::ST_PARA;
        else begin
          a.status = ffra_pkg::ST_OK;
          a.die = r_die[r];
          a.rid = r_start[r] + q.idx;
        end
      end
      default: a.status = ffra_pkg::ST_PARA;
    endcase
    return a;
  endfunction

  task automatic send_request(request_t q, logic has_exp, answer_t exp);
    answer_t a;
    int gap;
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 60) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) in_valid_i <= 1'b0;
    repeat (gap) @(posedge clk_i);
    in_valid_i <= 1'b1;
    {mode_i, res_type_i, die_i, count_i, start_id_i, handle_i, instance_req_i, index_i} <= q;
    do @(posedge clk_i); while (!in_ready_o);
    a = allocate_step(q);
    if (a.status == ffra_pkg::ST_OK && q.mode == ffra_pkg::MODE_ACQ) n_ok_acq++;
    if (has_exp && exp != a) begin
      mismatches++;
      if (mismatches <= 10)
        $display("table row disagrees with model: mode %0d exp %h model %h", q.mode, exp, a);
    end
    answers_due.insert(answers_due.size(), a);
    n_sent++;
  endtask

  function automatic request_t rand_request(logic [63:0] inst_a, logic [63:0] inst_b);
    request_t q;
    int sel;
    q = '0;
    q.rtype = 1'($urandom_range(0, 1));
    q.die = 1'($urandom_range(0, 1));
    q.inst = $urandom_range(0, 1) ? inst_a : inst_b;
    q.idx = $urandom_range(0, 3) == 0 ? 12'($urandom) : 12'($urandom_range(0, 40));
    q.handle = $urandom_range(0, 9) == 0 ? $urandom : m_counter - $urandom_range(0, 40);
    sel = $urandom_range(0, 99);
    if (sel < 25) begin
      q.mode = ffra_pkg::MODE_ADD;
      q.sid = 12'($urandom);
      q.count = $urandom_range(0, 9) == 0 ? 13'($urandom) : 13'($urandom_range(0, 200));
      if (32'(q.sid) + 32'(q.count) > ffra_pkg::RES_IDS && $urandom_range(0, 3) != 0)
        q.sid = 12'(ffra_pkg::RES_IDS - 32'(q.count));
    end else if (sel < 55) begin
      q.mode = ffra_pkg::MODE_ACQ;
      q.count = $urandom_range(0, 19) == 0 ? 13'($urandom) : 13'($urandom_range(0, 64));
    end else if (sel < 72) begin
      q.mode = ffra_pkg::MODE_REL;
    end else if (sel < 77) begin
      q.mode = ffra_pkg::MODE_REL_INST;
      if ($urandom_range(0, 4) == 0) q.inst = {$urandom, $urandom};
    end else if (sel < 97) begin
      q.mode = ffra_pkg::MODE_QUERY;
    end else begin
      q.mode = 3'($urandom_range(5, 7));
      q.count = 13'($urandom);
    end
    if ($urandom_range(0, 49) == 0) q.sid = 12'($urandom);
    return q;
  endfunction

  function automatic row_t mk(logic [2:0] m, logic t, logic d, logic [12:0] c, logic [11:0] s,
                              logic [31:0] h, logic [63:0] i, logic [11:0] x, logic he,
                              logic [2:0] st, logic [31:0] ho, logic dd, logic [11:0] rid);
    row_t r;
    r.req = '{m, t, d, c, s, h, i, x};
    r.has_exp = he;
    r.exp = '{st, ho, dd, rid};
    return r;
  endfunction

  // receiver with random stalls
  always @(posedge clk_i) begin
    answer_t got, want;
    if (out_valid_o && out_ready_i) begin
      got = '{status_o, handle_out_o, die_out_o, res_id_out_o};
      n_got++;
      if (answers_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
      end else begin
        want = answers_due.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result %0d: exp st %0d h %h d %0d id %h, got st %0d h %h d %0d id %h",
                     n_got, want.status, want.handle, want.die, want.rid,
                     got.status, got.handle, got.die, got.rid);
        end
      end
    end
    if (hold_rx) out_ready_i <= 1'b0;
    else if ($urandom_range(0, 19) == 0) out_ready_i <= 1'b0;
    else if ($urandom_range(0, 2) != 0) out_ready_i <= 1'b1;
  end

  // hold off the receiver for a long stretch
  initial begin
    wait (n_sent == 80);
    @(posedge clk_i);
    hold_rx <= 1'b1;
    repeat (800) @(posedge clk_i);
    hold_rx <= 1'b0;
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog expired, %0d results outstanding", answers_due.size());
      $display("first_fit_range_allocator: mismatch");
      $finish;
    end
  end

  initial begin
    logic [63:0] ia, ib;
    ia = 64'hFFFF_FFFF_FFFF_FFFF;
    ib = 64'h0;
    for (int p = 0; p < ffra_pkg::POOLS; p++) m_used[p] = 0;
    for (int i = 0; i < ffra_pkg::RECORDS; i++) r_valid[i] = 0;
    m_counter = 0;
    add_row(mk(ffra_pkg::MODE_QUERY, 0, 0, 0, 0, 0, 0, 0, 1, ffra_pkg::ST_NOTFOUND, 0, 0, 0));
    add_row(mk(ffra_pkg::MODE_ACQ, 0, 0, 1, 0, 0, 0, 0, 1, ffra_pkg::ST_UNAVAIL, 0, 0, 0));
    add_row(mk(ffra_pkg::MODE_ADD, 1, 1, 4096, 0, 0, 0, 0, 1, ffra_pkg::ST_OK, 0, 0, 0));
    add_row(mk(ffra_pkg::MODE_ADD, 0, 0, 1, 4095, 0, 0, 0, 1, ffra_pkg::ST_OK, 0, 0, 0));
    add_row(mk(ffra_pkg::MODE_ADD, 0, 0, 2, 4095, 0, 0, 0, 1, ffra_pkg::ST_PARA, 0, 0, 0));
    add_row(mk(ffra_pkg::MODE_ADD, 0, 1, 8191, 4095, 0, 0, 0, 1, ffra_pkg::ST_PARA, 0, 0, 0));
    add_row(mk(ffra_pkg::MODE_ADD, 0, 0, 0, 100, 0, 0, 0, 1, ffra_pkg::ST_OK, 0, 0, 0));
    add_row(mk(ffra_pkg::MODE_ACQ, 0, 0, 0, 0, 0, 0, 0, 1, ffra_pkg::ST_PARA, 0, 0, 0));
    add_row(mk(ffra_pkg::MODE_ACQ, 1, 1, 4096, 0, 0, ia, 0, 1, ffra_pkg::ST_OK, 1, 1, 0));
    add_row(mk(ffra_pkg::MODE_QUERY, 1, 0, 0, 0, 1, 0, 4095, 1, ffra_pkg::ST_OK, 0, 1, 4095));
    add_row(mk(ffra_pkg::MODE_QUERY, 0, 0, 0, 0, 1, 0, 0, 1, ffra_pkg::ST_PARA, 0, 0, 0));
    add_row(mk(ffra_pkg::MODE_ACQ, 0, 0, 1, 0, 0, ib, 0, 1, ffra_pkg::ST_OK, 2, 0, 4095));
    add_row(mk(ffra_pkg::MODE_QUERY, 0, 0, 0, 0, 2, 0, 1, 1, ffra_pkg::ST_PARA, 0, 0, 0));
    add_row(mk(ffra_pkg::MODE_REL, 0, 0, 0, 0, 32'hFFFF_FFFF, 0, 0, 1,
               ffra_pkg::ST_NOTFOUND, 0, 0, 0));
    add_row(mk(ffra_pkg::MODE_REL, 0, 0, 0, 0, 2, 0, 0, 1, ffra_pkg::ST_OK, 0, 0, 0));
    add_row(mk(ffra_pkg::MODE_REL_INST, 0, 0, 0, 0, 0, ia, 0, 1, ffra_pkg::ST_OK, 0, 0, 0));
    add_row(mk(ffra_pkg::MODE_REL_INST, 0, 0, 0, 0, 0, 64'h5A, 0, 1,
               ffra_pkg::ST_OK, 0, 0, 0));
    add_row(mk(3'd5, 1, 1, 8191, 4095, 0, 0, 0, 1, ffra_pkg::ST_PARA, 0, 0, 0));
    add_row(mk(3'd6, 0, 0, 0, 0, 0, 0, 0, 1, ffra_pkg::ST_PARA, 0, 0, 0));
    add_row(mk(3'd7, 0, 0, 0, 0, 0, 0, 0, 1, ffra_pkg::ST_PARA, 0, 0, 0));
    // fill a list, then the record table
    for (int k = 0; k < 17; k++)
      add_row(mk(ffra_pkg::MODE_ADD, 0, 1, 2, 12'(2 * k), 0, 0, 0, 0, 0, 0, 0, 0));
    for (int k = 0; k < 33; k++)
      add_row(mk(ffra_pkg::MODE_ACQ, 0, 1, 1, 0, 0, ia, 0, 0, 0, 0, 0, 0));
    add_row(mk(ffra_pkg::MODE_ADD, 0, 1, 1, 500, 0, 0, 0, 0, 0, 0, 0, 0));
    add_row(mk(ffra_pkg::MODE_REL_INST, 0, 0, 0, 0, 0, ia, 0, 0, 0, 0, 0, 0));
    add_row(mk(ffra_pkg::MODE_REL, 0, 0, 0, 0, 20, 0, 0, 0, 0, 0, 0, 0));

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (rows[i]) send_request(rows[i].req, rows[i].has_exp, rows[i].exp);
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n % 300 == 0) begin
        ia = {$urandom, $urandom};
        ib = {$urandom, $urandom};
      end
      send_request(rand_request(ia, ib), 0, '0);
    end
    in_valid_i <= 1'b0;
    while (answers_due.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    $display("sent %0d requests (%0d table rows), %0d successful acquires, %0d results",
             n_sent, rows.size(), n_ok_acq, n_got);
    if (mismatches == 0) begin
      $display("first_fit_range_allocator: match");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("first_fit_range_allocator: mismatch");
    end
    $finish;
  end

endmodule

FILE: sim.f
sv/ffra_pkg.sv
sv/ffra_ram.sv
sv/ffra_ctrl.sv
sv/ffra_dp.sv
sv/first_fit_range_allocator.sv
sv/ffra_chk.sv
tb/tb_top.sv
